// ===== src/prv_position_controller_macros.svh =====
// Assertion macros for the valve position controller checker.
// Expects signals named clock and reset in the scope of use.
`ifndef PRV_POSITION_CONTROLLER_MACROS_SVH
`define PRV_POSITION_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PRVPC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication after a fixed number of cycles, disabled during reset
`define PRVPC_ASSERT_DLY(label, ante, n, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##(n) (cons)) \
      else $error(msg);

`endif

// ===== src/prvpc_pkg.sv =====
// Shared types and constants of the valve position controller.
// No dependencies; used by the top level and its checker.
package prvpc_pkg;

   localparam int Q_W        = 32;
   localparam int QUO_W      = 22;
   localparam int NUM_W      = 60;
   localparam int DEN_W      = 63;
   localparam int D_W        = 45;
   localparam int PRE_STAGES = 5;
   localparam int PIPE_DEPTH = PRE_STAGES + QUO_W + 1;

   localparam logic signed [Q_W-1:0] Q_ONE = 32'sh0001_0000;

   // time of day: t mod 86400 = ((t >> 7) mod 675) << 7 | t[6:0]
   localparam int            DAY_SHIFT   = 7;
   localparam logic [10:0]   DAY_ODD     = 11'd675;
   localparam logic [25:0]   RECIP       = 26'd50903316;
   localparam int            RECIP_SHIFT = 35;
   localparam logic [10:0]   NIGHT_ROW   = 11'd196;
   localparam logic [6:0]    NIGHT_LOW   = 7'd112;

   // chamber area and gains folded into integers
   localparam logic [7:0]    K5          = 8'd130;
   localparam logic [21:0]   K6_Q        = 22'd3670016;
   localparam logic [D_W-1:0] D_CAP      = 45'h1000_0000_0000;
   localparam logic [9:0]    GAIN_OPEN   = 10'd627;
   localparam logic [9:0]    GAIN_CLOSE  = 10'd57;
   localparam logic [18:0]   DEN_OPEN    = 19'd470000;
   localparam logic [18:0]   DEN_CLOSE   = 19'd4700;

   typedef enum logic [1:0] {
      SCHEME_FIXED,
      SCHEME_TIME,
      SCHEME_FLOW,
      SCHEME_REMOTE
   } scheme_type;

   typedef enum logic [2:0] {
      CSR_SCHEME,
      CSR_FIXED_REF,
      CSR_NIGHT_REF,
      CSR_DAY_REF,
      CSR_REMOTE_REF,
      CSR_COEF_A,
      CSR_COEF_B,
      CSR_COEF_C
   } csr_index_type;

   typedef struct packed {
      logic        [31:0] time_s;
      logic signed [31:0] position;
      logic signed [31:0] last_position;
      logic signed [31:0] outlet_head;
      logic signed [31:0] outlet_elevation;
      logic signed [31:0] remote_head;
      logic signed [31:0] remote_elevation;
      logic signed [31:0] valve_flow;
      logic               valve_open;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_position;
      logic signed [31:0] target_pressure;
   } rsp_type;

endpackage

// ===== src/prv_position_controller.sv =====
// Each accepted beat passes the stage registers s1 to s4, the divider registers and the result register.
// Throughput: one beat per cycle; busy stays low and results need no slot.
// The quotient comes from a 22-stage restoring divider, one bit per stage.
// Synchronous active-high reset clears all valid bits and the configuration registers, not the payload.
// Results show for one cycle only; the receiver cannot stall them.
module prv_position_controller import prvpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   typedef struct packed {
      logic        [63:0] q2_full;
      logic        [63:0] bq_full;
      logic               bq_neg;
      logic        [63:0] sq_full;
      logic        [50:0] um;
      logic        [24:0] u;
      logic        [6:0]  t_low;
      logic signed [32:0] p_ctl;
      logic signed [31:0] last;
      logic               open;
   } s1_type;

   typedef struct packed {
      logic        [63:0]    alo;
      logic        [47:0]    ahi;
      logic        [D_W-1:0] d;
      logic        [10:0]    r;
      logic        [6:0]     t_low;
      logic        [47:0]    bmag;
      logic                  bq_neg;
      logic signed [32:0]    p_ctl;
      logic signed [31:0]    last;
      logic                  open;
   } s2_type;

   typedef struct packed {
      logic signed [49:0]      pa;
      logic signed [49:0]      pb;
      logic                    night;
      logic        [DEN_W-1:0] den_open;
      logic        [DEN_W-1:0] den_close;
      logic signed [32:0]      p_ctl;
      logic signed [31:0]      last;
      logic                    open;
   } s3_type;

   typedef struct packed {
      logic signed [31:0]      ref_p;
      logic        [DEN_W-1:0] den_open;
      logic        [DEN_W-1:0] den_close;
      logic signed [32:0]      p_ctl;
      logic signed [31:0]      last;
      logic                    open;
   } s4_type;

   typedef struct packed {
      logic        [NUM_W-1:0] rem;
      logic        [DEN_W-1:0] den;
      logic        [QUO_W-1:0] quo;
      logic                    neg;
      logic signed [31:0]      ref_p;
      logic signed [31:0]      last;
      logic                    open;
   } div_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] res;
      if (v > 64'sd2147483647) begin
         res = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         res = 32'sh8000_0000;
      end else begin
         res = 32'(v);
      end
      return res;
   endfunction

   scheme_type         scheme_ff;
   logic signed [31:0] fixed_ref_ff, night_ref_ff, day_ref_ff, remote_ref_ff;
   logic signed [31:0] coef_a_ff, coef_b_ff, coef_c_ff;

   s1_type  s1_in, s1_ff;
   s2_type  s2_in, s2_ff;
   s3_type  s3_in, s3_ff;
   s4_type  s4_in, s4_ff;
   div_type div_in [QUO_W+1];
   div_type div_ff [QUO_W+1];
   logic    s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic    div_valid_ff [QUO_W+1];
   rsp_type rsp_data_in, rsp_data_ff;
   logic    rsp_strobe_ff;

   assign busy = 1'b0;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scheme_ff     <= SCHEME_FIXED;
         fixed_ref_ff  <= '0;
         night_ref_ff  <= '0;
         day_ref_ff    <= '0;
         remote_ref_ff <= '0;
         coef_a_ff     <= '0;
         coef_b_ff     <= '0;
         coef_c_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SCHEME:     scheme_ff     <= scheme_type'(csr_wdata[1:0]);
            CSR_FIXED_REF:  fixed_ref_ff  <= csr_wdata;
            CSR_NIGHT_REF:  night_ref_ff  <= csr_wdata;
            CSR_DAY_REF:    day_ref_ff    <= csr_wdata;
            CSR_REMOTE_REF: remote_ref_ff <= csr_wdata;
            CSR_COEF_A:     coef_a_ff     <= csr_wdata;
            CSR_COEF_B:     coef_b_ff     <= csr_wdata;
            CSR_COEF_C:     coef_c_ff     <= csr_wdata;
         endcase
      end
   end

   // Stage 1: squares, flow products, day reciprocal, controlled pressure
   always_comb begin
      logic [31:0] qm, pm, bm;
      logic signed [32:0] p_out, p_rem;
      qm = mag32(req_data.valve_flow);
      pm = mag32(req_data.position);
      bm = mag32(coef_b_ff);
      p_out = 33'(req_data.outlet_head) - 33'(req_data.outlet_elevation);
      p_rem = 33'(req_data.remote_head) - 33'(req_data.remote_elevation);
      s1_in.q2_full = 64'(qm) * 64'(qm);
      s1_in.bq_full = 64'(bm) * 64'(qm);
      s1_in.bq_neg  = coef_b_ff[31] ^ req_data.valve_flow[31];
      s1_in.sq_full = 64'(pm) * 64'(pm);
      s1_in.u       = req_data.time_s[31:DAY_SHIFT];
      s1_in.um      = 51'(req_data.time_s[31:DAY_SHIFT]) * 51'(RECIP);
      s1_in.t_low   = req_data.time_s[DAY_SHIFT-1:0];
      s1_in.p_ctl   = (scheme_ff == SCHEME_REMOTE) ? p_rem : p_out;
      s1_in.last    = req_data.last_position;
      s1_in.open    = req_data.valve_open;
   end

   // Stage 2: split a*q^2, chamber area with cap, coarse day remainder
   always_comb begin
      logic [47:0] q2, p2;
      logic [31:0] am;
      logic [55:0] d_raw;
      logic [15:0] qe;
      logic [24:0] r_raw;
      q2 = s1_ff.q2_full[63:16];
      p2 = s1_ff.sq_full[63:16];
      am = mag32(coef_a_ff);
      d_raw = 56'(p2) * 56'(K5) + 56'(K6_Q);
      qe = 16'(s1_ff.um >> RECIP_SHIFT);
      r_raw = s1_ff.u - 25'(qe) * 25'(DAY_ODD);
      s2_in.alo    = 64'(am) * 64'(q2[31:0]);
      s2_in.ahi    = 48'(am) * 48'(q2[47:32]);
      s2_in.d      = (d_raw > 56'(D_CAP)) ? D_CAP : d_raw[D_W-1:0];
      s2_in.r      = r_raw[10:0];
      s2_in.t_low  = s1_ff.t_low;
      s2_in.bmag   = s1_ff.bq_full[63:16];
      s2_in.bq_neg = s1_ff.bq_neg;
      s2_in.p_ctl  = s1_ff.p_ctl;
      s2_in.last   = s1_ff.last;
      s2_in.open   = s1_ff.open;
   end

   // Stage 3: finish a*q^2 with saturation, night window, divisor variants
   always_comb begin
      logic [79:0] full;
      logic [48:0] pa_mag;
      logic signed [49:0] pa_pos, pb_pos;
      logic [10:0] r2;
      full = 80'(s2_ff.alo) + {s2_ff.ahi, 32'b0};
      pa_mag = (full[79:64] != 16'd0) ? 49'h1_0000_0000_0000 : 49'(full[63:16]);
      pa_pos = $signed({1'b0, pa_mag});
      pb_pos = $signed({2'b0, s2_ff.bmag});
      r2 = (s2_ff.r >= DAY_ODD) ? s2_ff.r - DAY_ODD : s2_ff.r;
      s3_in.pa        = coef_a_ff[31] ? -pa_pos : pa_pos;
      s3_in.pb        = s2_ff.bq_neg ? -pb_pos : pb_pos;
      s3_in.night     = (r2 < NIGHT_ROW) || ((r2 == NIGHT_ROW) && (s2_ff.t_low <= NIGHT_LOW));
      s3_in.den_open  = 63'(s2_ff.d) * 63'(DEN_OPEN);
      s3_in.den_close = 63'(s2_ff.d) * 63'(DEN_CLOSE);
      s3_in.p_ctl     = s2_ff.p_ctl;
      s3_in.last      = s2_ff.last;
      s3_in.open      = s2_ff.open;
   end

   // Stage 4: pick the reference pressure
   always_comb begin
      logic signed [51:0] flow_sum;
      flow_sum = 52'(s3_ff.pa) + 52'(s3_ff.pb) + 52'(coef_c_ff);
      unique case (scheme_ff)
         SCHEME_FIXED:  s4_in.ref_p = fixed_ref_ff;
         SCHEME_TIME:   s4_in.ref_p = s3_ff.night ? night_ref_ff : day_ref_ff;
         SCHEME_FLOW:   s4_in.ref_p = sat32(64'(flow_sum));
         SCHEME_REMOTE: s4_in.ref_p = remote_ref_ff;
      endcase
      s4_in.den_open  = s3_ff.den_open;
      s4_in.den_close = s3_ff.den_close;
      s4_in.p_ctl     = s3_ff.p_ctl;
      s4_in.last      = s3_ff.last;
      s4_in.open      = s3_ff.open;
   end

   // Stage 5: error, scaled numerator and divisor for the chosen direction;
   // divider stages: resolve one quotient bit per stage, most significant first
   always_comb begin
      logic signed [33:0] err;
      logic [33:0] em;
      logic [43:0] scaled;
      int k;
      err = 34'(s4_ff.ref_p) - 34'(s4_ff.p_ctl);
      em = err[33] ? 34'(-err) : 34'(err);
      scaled = 44'(em) * 44'(err[33] ? GAIN_CLOSE : GAIN_OPEN);
      div_in[0].rem   = {scaled, 16'b0};
      div_in[0].den   = err[33] ? s4_ff.den_close : s4_ff.den_open;
      div_in[0].quo   = '0;
      div_in[0].neg   = err[33];
      div_in[0].ref_p = s4_ff.ref_p;
      div_in[0].last  = s4_ff.last;
      div_in[0].open  = s4_ff.open;
      for (int i = 0; i < QUO_W; i++) begin
         k = QUO_W - 1 - i;
         div_in[i+1] = div_ff[i];
         if (63'(div_ff[i].rem >> k) >= div_ff[i].den) begin
            div_in[i+1].rem    = div_ff[i].rem - NUM_W'(div_ff[i].den << k);
            div_in[i+1].quo[k] = 1'b1;
         end
      end
   end

   // Final: apply delta, saturate, force open, clamp at full open
   always_comb begin
      logic signed [QUO_W:0] q_pos, delta;
      logic signed [31:0] np;
      q_pos = $signed({1'b0, div_ff[QUO_W].quo});
      delta = div_ff[QUO_W].neg ? -q_pos : q_pos;
      np = sat32(64'(div_ff[QUO_W].last) + 64'(delta));
      if (div_ff[QUO_W].open || (np > Q_ONE)) begin
         np = Q_ONE;
      end
      rsp_data_in.new_position    = np;
      rsp_data_in.target_pressure = div_ff[QUO_W].ref_p;
   end

   // Advance valid bits every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i <= QUO_W; i++) begin
            div_valid_ff[i] <= 1'b0;
         end
      end else begin
         s1_valid_ff     <= start && !busy;
         s2_valid_ff     <= s1_valid_ff;
         s3_valid_ff     <= s2_valid_ff;
         s4_valid_ff     <= s3_valid_ff;
         div_valid_ff[0] <= s4_valid_ff;
         for (int i = 0; i < QUO_W; i++) begin
            div_valid_ff[i+1] <= div_valid_ff[i];
         end
         rsp_strobe_ff <= div_valid_ff[QUO_W];
      end
   end

   // Advance payload every cycle
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
      for (int i = 0; i <= QUO_W; i++) begin
         div_ff[i] <= div_in[i];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== src/prvpc_checker.sv =====
// Port-level checks of the valve position controller, bound to the top level.
// Depends on prvpc_pkg and prv_position_controller_macros.svh.
`include "prv_position_controller_macros.svh"

module prvpc_checker import prvpc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // Every accepted beat yields its result after the fixed latency
   `PRVPC_ASSERT_DLY(a_result_due, start && !busy, PIPE_DEPTH, rsp_strobe, "result missing")

   // No result without a beat accepted one latency earlier
   `PRVPC_ASSERT_IMP(a_no_ghost, rsp_strobe, $past(start && !busy, PIPE_DEPTH), "spurious result")

   // Position never exceeds full open
   `PRVPC_ASSERT_IMP(a_clamp, rsp_strobe, rsp_data.new_position <= Q_ONE, "position above 1.0")

   // An open valve reports full open
   `PRVPC_ASSERT_IMP(a_open, rsp_strobe && $past(start && !busy && req_data.valve_open, PIPE_DEPTH), rsp_data.new_position == Q_ONE, "open valve not at 1.0")

endmodule

bind prv_position_controller prvpc_checker u_prvpc_checker (.*);

// ===== tb/tb.sv =====
// Self-checking bench for the valve position controller.
// Depends on prvpc_pkg and prv_position_controller; predicts each beat in-bench.
`timescale 1ns / 100ps

module tb;
   import prvpc_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   typedef struct {
      req_type item;
      bit      known;
      rsp_type want;
   } step_row_type;

   // predictor copy of the registers
   scheme_type  mdl_scheme;
   logic signed [31:0] mdl_regs [8];

   rsp_type     pending_positions [$];
   int          accepted_count;
   int          fail_count;
   bit          cur_known;
   rsp_type     cur_want;
   step_row_type directed_rows [$];

   prv_position_controller dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // fixed-point product, truncated toward zero, saturated past 64 bits
   function automatic longint fx_mul(longint x, longint y);
      logic [127:0] prod;
      logic [63:0]  p;
      prod = 128'(magnitude(x)) * 128'(magnitude(y));
      p = (prod >= (128'd1 << 64)) ? (64'd1 << 48) : 64'(prod >> 16);
      return ((x < 0) != (y < 0)) ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint sat_32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic rsp_type predict_position(req_type r);
      longint       tgt, err, delta, np, pres, q;
      logic [127:0] p2, d, num, den, quo;
      rsp_type      res;
      q = longint'(r.valve_flow);
      case (mdl_scheme)
         SCHEME_FIXED: tgt = mdl_regs[CSR_FIXED_REF];
         SCHEME_TIME: begin
            tgt = ((r.time_s % 32'd86400) <= 32'd25200) ? mdl_regs[CSR_NIGHT_REF]
                                                       : mdl_regs[CSR_DAY_REF];
         end
         SCHEME_FLOW: begin
            tgt = sat_32(fx_mul(mdl_regs[CSR_COEF_A],
                                longint'((magnitude(q) * magnitude(q)) >> 16))
                         + fx_mul(mdl_regs[CSR_COEF_B], q) + mdl_regs[CSR_COEF_C]);
         end
         default: tgt = mdl_regs[CSR_REMOTE_REF];
      endcase
      if (mdl_scheme == SCHEME_REMOTE)
         pres = longint'(r.remote_head) - longint'(r.remote_elevation);
      else
         pres = longint'(r.outlet_head) - longint'(r.outlet_elevation);
      err = tgt - pres;
      // chamber area grows with position squared, capped
      p2 = (128'(magnitude(longint'(r.position))) ** 2) >> 16;
      d = 128'd130 * p2 + 128'd56 * 128'd65536;
      if (d > (128'd1 << 44)) d = 128'd1 << 44;
      if (err >= 0) begin
         num = 128'd627 * 128'd65536 * 128'(magnitude(err));
         den = 128'd470000 * d;
      end else begin
         num = 128'd57 * 128'd65536 * 128'(magnitude(err));
         den = 128'd4700 * d;
      end
      quo = num / den;
      delta = err < 0 ? -longint'(quo) : longint'(quo);
      np = sat_32(longint'(r.last_position) + delta);
      if (r.valve_open) np = 65536;
      if (np > 65536) np = 65536;
      res.new_position = np[31:0];
      res.target_pressure = tgt[31:0];
      return res;
   endfunction

   // track registers, queue predictions, check result beats
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mdl_scheme = SCHEME_FIXED;
         for (int i = 0; i < 8; i++) mdl_regs[i] = '0;
      end else begin
         if (start && !busy) begin
            pending_positions.push_back(cur_known ? cur_want : predict_position(req_data));
            accepted_count++;
         end
         if (rsp_strobe) begin
            if (pending_positions.size() == 0) begin
               $error("result beat with nothing pending");
               fail_count++;
            end else begin
               want = pending_positions.pop_front();
               if (rsp_data.new_position !== want.new_position) begin
                  $error("new_position exp %0d got %0d", want.new_position,
                         rsp_data.new_position);
                  fail_count++;
               end
               if (rsp_data.target_pressure !== want.target_pressure) begin
                  $error("target_pressure exp %0d got %0d", want.target_pressure,
                         rsp_data.target_pressure);
                  fail_count++;
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_SCHEME) mdl_scheme = scheme_type'(csr_wdata[1:0]);
            else mdl_regs[csr_index] = csr_wdata;
         end
      end
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   // hold the beat until the block takes it
   task automatic send_beat(req_type item, bit known, rsp_type want);
      int prev;
      prev = accepted_count;
      start <= 1'b1;
      req_data <= item;
      cur_known = known;
      cur_want = want;
      do @(negedge clock); while (accepted_count == prev);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_positions.size() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_q();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h7fff_ffff;
         2: return 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 400000)) - 200000);
      endcase
   endfunction

   function automatic req_type random_item();
      req_type r;
      r.time_s = ($urandom_range(0, 2) == 0) ? $urandom()
               : $urandom_range(0, 20) * 86400 + 25200 + $urandom_range(0, 2) - 1;
      r.position = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 98304);
      r.last_position = ($urandom_range(0, 3) == 0) ? $urandom()
                        : $urandom_range(0, 98304);
      r.outlet_head = pick_q();
      r.outlet_elevation = pick_q();
      r.remote_head = pick_q();
      r.remote_elevation = pick_q();
      r.valve_flow = pick_q();
      r.valve_open = ($urandom_range(0, 7) == 0);
      return r;
   endfunction

   function automatic void add_row(req_type item, bit known, rsp_type want);
      step_row_type row;
      row.item = item;
      row.known = known;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   initial begin
      req_type r;
      rsp_type w;
      int burst;
      int gap;
      fail_count = 0;
      accepted_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_SCHEME;
      csr_wdata = '0;
      cur_known = 1'b0;
      cur_want = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows under reset registers: zero error leaves last position
      r = '0; w = '0;
      add_row(r, 1, w);
      r.valve_open = 1'b1; w.new_position = Q_ONE;
      add_row(r, 1, w);
      r = '0; r.last_position = 32'h7fff_ffff; w.new_position = Q_ONE;
      add_row(r, 1, w);
      r.last_position = 32'h8000_0000; w.new_position = 32'h8000_0000;
      add_row(r, 1, w);
      r = '1; r.valve_open = 1'b0;
      add_row(r, 0, w);
      r = '0; r.outlet_head = 32'h7fff_ffff; r.outlet_elevation = 32'h8000_0000;
      add_row(r, 0, w);
      r.outlet_head = 32'h8000_0000; r.outlet_elevation = 32'h7fff_ffff;
      r.last_position = 32'h8000_0000;
      add_row(r, 0, w);
      r.position = 32'h7fff_ffff;
      add_row(r, 0, w);
      r.position = 32'h8000_0000; r.last_position = 32'h7fff_ffff;
      add_row(r, 0, w);
      r.position = Q_ONE; r.outlet_head = -32'sd65536; r.outlet_elevation = '0;
      r.last_position = '0;
      add_row(r, 0, w);
      foreach (directed_rows[i])
         send_beat(directed_rows[i].item, directed_rows[i].known, directed_rows[i].want);
      drain();

      // random phases, one register setting each
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_SCHEME, ph % 4);
         for (int k = 1; k < 8; k++) begin
            case (ph)
               4: write_csr(csr_index_type'(k), 32'h7fff_ffff);
               5: write_csr(csr_index_type'(k), 32'h8000_0000);
               default: write_csr(csr_index_type'(k),
                                  ($urandom_range(0, 1) == 0) ? $urandom() : pick_q());
            endcase
         end
         csr_we <= 1'b0;
         @(negedge clock);
         burst = 0;
         for (int n = 0; n < 100; n++) begin
            // bursts with random gaps, phase 2 runs back to back
            if (burst == 0) begin
               burst = $urandom_range(1, 20);
               gap = $urandom_range(0, 30);
               if ((ph != 2) && (gap != 0)) begin
                  start <= 1'b0;
                  repeat (gap) @(negedge clock);
               end
            end
            burst--;
            send_beat(random_item(), 0, w);
         end
         drain();
      end

      repeat (40) @(negedge clock);
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #1000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
